// File: rtl/kwh_pkg.sv
// Shared constants for the k-bit word histogram block.
`default_nettype none

package kwh_pkg;

    localparam int MAX_WORD_BITS_DEF = 12;
    localparam int COUNT_WIDTH_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF   = 4;
    localparam int RES_DEPTH_DEF     = 2;

    localparam int WORD_BITS_W   = 4;
    localparam int DATA_BYTE_W   = 8;
    localparam int ENTRY_INDEX_W = 12;
    localparam int ENTRY_COUNT_W = 32;

    localparam logic [WORD_BITS_W-1:0] WORD_BITS_RESET = 4'd8;

    // Input command codes.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Operation codes carried in the work queue.
    localparam logic OP_INCR = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

`default_nettype wire

// File: rtl/kwh_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module kwh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/kwh_fifo.sv
// Small register-based FIFO used for the work queue and the result queue.
`default_nettype none

module kwh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           rdata,
    output logic                            full,
    output logic                            empty,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/kwh_front.sv
// Front end: takes commands, cuts bytes into words and queues the histogram operations.
`default_nettype none

module kwh_front #(
    parameter int MAX_WORD_BITS = kwh_pkg::MAX_WORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              word_bits_we,
    input  wire logic [kwh_pkg::WORD_BITS_W-1:0]   word_bits,
    input  wire logic                              push,
    input  wire logic                              command,
    input  wire logic [kwh_pkg::DATA_BYTE_W-1:0]   data_byte,
    input  wire logic [kwh_pkg::ENTRY_INDEX_W-1:0] entry_index,
    input  wire logic                              clearing,
    output logic                                   full,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output logic      [MAX_WORD_BITS:0]            q_data
);

    localparam int AW = MAX_WORD_BITS + 7;
    localparam int CW = $clog2(MAX_WORD_BITS + 8);

    logic [kwh_pkg::WORD_BITS_W-1:0] word_bits_reg;
    logic [kwh_pkg::WORD_BITS_W-1:0] word_bits_next;
    logic [AW-1:0]                   acc_reg;
    logic [AW-1:0]                   acc_next;
    logic [CW-1:0]                   cnt_reg;
    logic [CW-1:0]                   cnt_next;
    logic                            busy_reg;
    logic                            busy_next;

    logic [CW-1:0]                   k;
    logic [MAX_WORD_BITS-1:0]        mask;
    logic [CW-1:0]                   cnt_sub;
    logic [CW-1:0]                   cnt_add;
    logic [AW-1:0]                   acc_shifted;
    logic [AW+7:0]                   acc_joined;
    logic [MAX_WORD_BITS-1:0]        word;
    logic [MAX_WORD_BITS+11:0]       index_ext;
    logic                            accept;
    logic                            emit;

    // Effective word width: zero counts as one bit, large values stop at the maximum.
    always_comb
    begin
        if (word_bits_reg == '0)
        begin
            k = CW'(1);
        end
        else if (CW'(word_bits_reg) > CW'(MAX_WORD_BITS))
        begin
            k = CW'(MAX_WORD_BITS);
        end
        else
        begin
            k = CW'(word_bits_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_WORD_BITS; i++)
        begin
            mask[i] = (CW'(i) < k);
        end
    end

    assign cnt_sub     = cnt_reg - k;
    assign cnt_add     = cnt_reg + CW'(8);
    assign acc_shifted = acc_reg >> cnt_sub;
    assign word        = acc_shifted[MAX_WORD_BITS-1:0] & mask;
    assign acc_joined  = {acc_reg, data_byte};
    assign index_ext   = {{MAX_WORD_BITS{1'b0}}, entry_index};

    assign full   = busy_reg || q_full || clearing;
    assign accept = push && !full;
    assign emit   = busy_reg && !q_full;

    always_comb
    begin
        q_push = emit || (accept && (command == kwh_pkg::CMD_READ));
        if (busy_reg)
        begin
            q_data = {kwh_pkg::OP_INCR, word};
        end
        else
        begin
            q_data = {kwh_pkg::OP_READ, index_ext[MAX_WORD_BITS-1:0]};
        end
    end

    always_comb
    begin
        word_bits_next = word_bits_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        if (word_bits_we)
        begin
            word_bits_next = word_bits;
        end
        // Bits above the valid count are never looked at, so the shift needs no clean-up.
        if (accept && (command == kwh_pkg::CMD_PUSH))
        begin
            acc_next  = acc_joined[AW-1:0];
            cnt_next  = cnt_add;
            busy_next = (cnt_add >= k);
        end
        else if (emit)
        begin
            cnt_next  = cnt_sub;
            busy_next = (cnt_sub >= k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_bits_reg <= kwh_pkg::WORD_BITS_RESET;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            word_bits_reg <= word_bits_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            busy_reg      <= busy_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/kwh_back.sv
// Back end: clears the histogram after reset, then runs increments and reads on it.
`default_nettype none

module kwh_back #(
    parameter int MAX_WORD_BITS = kwh_pkg::MAX_WORD_BITS_DEF,
    parameter int COUNT_WIDTH   = kwh_pkg::COUNT_WIDTH_DEF,
    parameter int RES_DEPTH     = kwh_pkg::RES_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_empty,
    input  wire logic [MAX_WORD_BITS:0]              q_data,
    output logic                                     q_pop,
    input  wire logic [$clog2(RES_DEPTH+1)-1:0]      res_count,
    output logic                                     res_push,
    output logic      [kwh_pkg::ENTRY_COUNT_W-1:0]   res_data,
    output logic                                     clearing
);

    localparam int RCW = $clog2(RES_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [MAX_WORD_BITS-1:0] clr_addr_reg;
    logic [MAX_WORD_BITS-1:0] clr_addr_next;

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic                     s1_read_reg;
    logic                     s1_read_next;
    logic [MAX_WORD_BITS-1:0] s1_addr_reg;
    logic [MAX_WORD_BITS-1:0] s1_addr_next;

    logic                     fwd_valid_reg;
    logic                     fwd_valid_next;
    logic [MAX_WORD_BITS-1:0] fwd_addr_reg;
    logic [MAX_WORD_BITS-1:0] fwd_addr_next;
    logic [COUNT_WIDTH-1:0]   fwd_data_reg;
    logic [COUNT_WIDTH-1:0]   fwd_data_next;

    logic                     ram_we;
    logic [MAX_WORD_BITS-1:0] ram_waddr;
    logic [COUNT_WIDTH-1:0]   ram_wdata;
    logic [COUNT_WIDTH-1:0]   ram_rdata;

    logic [COUNT_WIDTH-1:0]   cur;
    logic [COUNT_WIDTH-1:0]   inc;
    logic [COUNT_WIDTH+31:0]  cur_ext;
    logic [RCW:0]             res_pending;
    logic                     room;
    logic                     s1_write;

    assign clearing = (state_reg == ST_CLEAR);

    // A read issued in the same cycle as a write to its address sees the old word,
    // so the last written count is forwarded.
    assign cur = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : ram_rdata;
    assign inc = (&cur) ? cur : cur + COUNT_WIDTH'(1);
    assign cur_ext = {32'b0, cur};

    assign s1_write = s1_valid_reg && (s1_read_reg == kwh_pkg::OP_INCR);
    assign res_push = s1_valid_reg && (s1_read_reg == kwh_pkg::OP_READ);
    assign res_data = cur_ext[kwh_pkg::ENTRY_COUNT_W-1:0];

    // A read in flight must find a free slot in the result queue.
    assign res_pending = {1'b0, res_count} + (RCW + 1)'(res_push);
    assign room        = (res_pending < (RCW + 1)'(RES_DEPTH));
    assign q_pop       = (state_reg == ST_RUN) && !q_empty && room;

    assign ram_we    = clearing || s1_write;
    assign ram_waddr = clearing ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clearing ? '0 : inc;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + MAX_WORD_BITS'(1);
                if (&clr_addr_reg)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next  = q_pop;
        s1_read_next   = q_data[MAX_WORD_BITS];
        s1_addr_next   = q_data[MAX_WORD_BITS-1:0];
        fwd_valid_next = s1_write;
        fwd_addr_next  = s1_addr_reg;
        fwd_data_next  = inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_read_reg  <= s1_read_next;
        s1_addr_reg  <= s1_addr_next;
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
    end

    kwh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (2 ** MAX_WORD_BITS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (q_pop),
        .raddr (q_data[MAX_WORD_BITS-1:0]),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// File: rtl/kbit_word_histogram_top.sv
// Top level of the k-bit word histogram block.
//
// Bytes pushed in are cut, most significant bit first, into words of word_bits bits
// (zero is taken as one, values above MAX_WORD_BITS as MAX_WORD_BITS), and each
// complete word adds one to its saturating histogram count; a read command returns
// the count at entry_index through the result queue. After reset the block sweeps
// the histogram RAM to zero, one entry a clock, and full stays high until all
// 2**MAX_WORD_BITS entries (4096 at the default) are cleared. A data byte then holds
// the input until the front end has handed each word it completes to the work
// queue, one word a cycle, waiting whenever that queue is full; the back end retires
// one read-modify-write a cycle on the RAM while the work queue has entries and the
// result queue has room, forwarding the last written count. A read command does not
// hold the input; its result passes through the work queue, the registered RAM read
// and the result queue to the output, waiting while earlier operations are queued or
// the result queue has no room. Leftover bits stay pending and are never counted on
// their own. word_bits is to be written only while idle.
`default_nettype none

module kbit_word_histogram_top #(
    parameter int MAX_WORD_BITS = kwh_pkg::MAX_WORD_BITS_DEF,
    parameter int COUNT_WIDTH   = kwh_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH   = kwh_pkg::QUEUE_DEPTH_DEF,
    parameter int RES_DEPTH     = kwh_pkg::RES_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              word_bits_we,
    input  wire logic [kwh_pkg::WORD_BITS_W-1:0]   word_bits,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              command,
    input  wire logic [kwh_pkg::DATA_BYTE_W-1:0]   data_byte,
    input  wire logic [kwh_pkg::ENTRY_INDEX_W-1:0] entry_index,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic      [kwh_pkg::ENTRY_COUNT_W-1:0] entry_count
);

    logic                              q_push;
    logic [MAX_WORD_BITS:0]            q_wdata;
    logic                              q_full;
    logic                              q_empty;
    logic                              q_pop;
    logic [MAX_WORD_BITS:0]            q_rdata;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_count;
    logic                              clearing;
    logic                              res_push;
    logic [kwh_pkg::ENTRY_COUNT_W-1:0] res_data;
    logic                              res_full;
    logic [$clog2(RES_DEPTH+1)-1:0]    res_count;
    logic                              q_over;
    logic                              res_over;

    // The front end never pushes into a full queue, nor the back end into a full result queue.
    assign q_over   = q_push && q_full && (q_count != '0);
    assign res_over = res_push && res_full;

    kwh_front #(
        .MAX_WORD_BITS (MAX_WORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_bits_we (word_bits_we),
        .word_bits    (word_bits),
        .push         (push),
        .command      (command),
        .data_byte    (data_byte),
        .entry_index  (entry_index),
        .clearing     (clearing),
        .full         (full),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_wdata)
    );

    kwh_fifo #(
        .WIDTH (MAX_WORD_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push && !q_over),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty),
        .count (q_count)
    );

    kwh_back #(
        .MAX_WORD_BITS (MAX_WORD_BITS),
        .COUNT_WIDTH   (COUNT_WIDTH),
        .RES_DEPTH     (RES_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .res_count (res_count),
        .res_push  (res_push),
        .res_data  (res_data),
        .clearing  (clearing)
    );

    kwh_fifo #(
        .WIDTH (kwh_pkg::ENTRY_COUNT_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push && !res_over),
        .wdata (res_data),
        .pop   (pop),
        .rdata (entry_count),
        .full  (res_full),
        .empty (empty),
        .count (res_count)
    );

endmodule

`default_nettype wire

// File: rtl/kwh_checker.sv
// Port-level checker for the k-bit word histogram block, with its bind.
`default_nettype none

module kwh_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              push,
    input wire logic                              full,
    input wire logic                              command,
    input wire logic                              empty,
    input wire logic                              pop,
    input wire logic [kwh_pkg::ENTRY_COUNT_W-1:0] entry_count
);

    logic [3:0] outstanding_reg;
    logic [3:0] outstanding_next;
    logic       read_in;
    logic       result_out;

    assign read_in    = push && !full && (command == kwh_pkg::CMD_READ);
    assign result_out = pop && !empty;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (read_in && !result_out)
        begin
            outstanding_next = outstanding_reg + 4'd1;
        end
        else if (result_out && !read_in)
        begin
            outstanding_next = outstanding_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // The histogram is being cleared straight after reset, so no input is taken.
    a_clear_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> full)
        else $error("input accepted while the histogram is being cleared");

    // A result only ever answers a read command taken earlier.
    a_result_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (outstanding_reg != 4'd0))
        else $error("result shown without an outstanding read");

    // With no read outstanding and none arriving, the result queue stays empty.
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        (outstanding_reg == 4'd0) && !read_in |=> empty)
        else $error("result appeared with no read outstanding");

    // A waiting result holds until it is taken.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(entry_count))
        else $error("waiting result changed before it was taken");

endmodule

bind kbit_word_histogram_top kwh_checker u_kwh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .command     (command),
    .empty       (empty),
    .pop         (pop),
    .entry_count (entry_count)
);

`default_nettype wire
